>>> rtl/ema_deadband_bang_bang_ctrl_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the EMA deadband bang-bang controller.
// The macros expect signals named clk and arst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef EMA_DEADBAND_BANG_BANG_CTRL_CORE_MACROS_SVH
`define EMA_DEADBAND_BANG_BANG_CTRL_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define EBB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ebb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EBB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ebb assertion failed");

`else

`define EBB_ASSERT_IMP(lbl, ante, cons)
`define EBB_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/ebb_pkg.sv
// ----------------------------------------------------------------------------
// ebb_pkg
// Shared widths, register indexes, drive codes and bundles of the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebb_pkg;

	localparam int DIST_BITS  = 13;
	localparam int FRAC_BITS  = 8;
	localparam int FILT_BITS  = DIST_BITS + FRAC_BITS;

	// Filter weight is always Q8, independent of the distance fraction.
	localparam int ALPHA_FRAC = 8;
	localparam int ALPHA_BITS = ALPHA_FRAC + 1;
	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1) << ALPHA_FRAC;

	localparam int PROD_BITS  = FILT_BITS + ALPHA_BITS;
	localparam int SUM_BITS   = PROD_BITS + 1;

	localparam int STAT_BITS  = 4;
	localparam int DB_BITS    = 8;
	localparam int CNT_BITS   = 8;
	localparam int DUTY_BITS  = 8;
	localparam int DIR_BITS   = 2;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = ALPHA_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRIME    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_INVALID  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DUTY     = 3'd4;

	localparam logic [ALPHA_BITS-1:0] RST_ALPHA    = 9'd102;
	localparam logic [DB_BITS-1:0]    RST_DEADBAND = 8'd5;
	localparam logic [CNT_BITS-1:0]   RST_PRIME    = 8'd20;
	localparam logic [STAT_BITS-1:0]  RST_INVALID  = 4'd4;
	localparam logic [DUTY_BITS-1:0]  RST_DUTY     = 8'd255;

	localparam logic [CNT_BITS-1:0]   CNT_MAX      = {CNT_BITS{1'b1}};

	localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_BITS-1:0] DIR_FWD  = 2'd1;
	localparam logic [DIR_BITS-1:0] DIR_REV  = 2'd2;

	typedef struct packed {
		logic [ALPHA_BITS-1:0] alpha_q8;
		logic [DB_BITS-1:0]    deadband_mm;
		logic [CNT_BITS-1:0]   prime_count;
		logic [STAT_BITS-1:0]  invalid_code;
		logic [DUTY_BITS-1:0]  drive_duty;
	} cfg_t;

	typedef struct packed {
		logic [DIR_BITS-1:0]  direction;
		logic [DUTY_BITS-1:0] duty;
		logic [DIST_BITS-1:0] filtered_mm;
		logic [DIST_BITS-1:0] target_mm;
		logic                 locked;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/ebb_ifs.sv
// ----------------------------------------------------------------------------
// ebb channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ebb_sample_if;
	logic                           valid;
	logic                           ready;
	logic [ebb_pkg::DIST_BITS-1:0]  distance_mm;
	logic [ebb_pkg::STAT_BITS-1:0]  range_status;

	modport source (output valid, output distance_mm, output range_status, input ready);
	modport sink   (input valid, input distance_mm, input range_status, output ready);
endinterface

interface ebb_result_if;
	logic                           valid;
	logic                           ready;
	logic [ebb_pkg::DIR_BITS-1:0]   direction;
	logic [ebb_pkg::DUTY_BITS-1:0]  duty;
	logic [ebb_pkg::DIST_BITS-1:0]  filtered_mm;
	logic [ebb_pkg::DIST_BITS-1:0]  target_mm;
	logic                           locked;

	modport source (output valid, output direction, output duty, output filtered_mm,
		output target_mm, output locked, input ready);
	modport sink   (input valid, input direction, input duty, input filtered_mm,
		input target_mm, input locked, output ready);
endinterface

interface ebb_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ebb_pkg::CFG_IDX_BITS-1:0]  index;
	logic [ebb_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/ebb_cfg_regs.sv
// ----------------------------------------------------------------------------
// ebb_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebb_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [ebb_pkg::CFG_IDX_BITS-1:0]  wr_idx,
	input  wire logic [ebb_pkg::CFG_DATA_BITS-1:0] wr_data,
	output ebb_pkg::cfg_t                          cfg
);
	import ebb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_q8     <= RST_ALPHA;
			cfg_q.deadband_mm  <= RST_DEADBAND;
			cfg_q.prime_count  <= RST_PRIME;
			cfg_q.invalid_code <= RST_INVALID;
			cfg_q.drive_duty   <= RST_DUTY;
		end else if (wr_en) begin
			case (wr_idx)
				REG_ALPHA:    cfg_q.alpha_q8     <= wr_data[ALPHA_BITS-1:0];
				REG_DEADBAND: cfg_q.deadband_mm  <= wr_data[DB_BITS-1:0];
				REG_PRIME:    cfg_q.prime_count  <= wr_data[CNT_BITS-1:0];
				REG_INVALID:  cfg_q.invalid_code <= wr_data[STAT_BITS-1:0];
				REG_DUTY:     cfg_q.drive_duty   <= wr_data[DUTY_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/ebb_loop.sv
// ----------------------------------------------------------------------------
// ebb_loop
// Filter, priming and setpoint state with the combinational update and decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebb_loop (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [ebb_pkg::DIST_BITS-1:0] raw,
	input  wire logic [ebb_pkg::STAT_BITS-1:0] status,
	input  ebb_pkg::cfg_t                      cfg,
	output ebb_pkg::res_t                      res
);
	import ebb_pkg::*;

	logic [FILT_BITS-1:0]  filter_q;
	logic [FILT_BITS-1:0]  target_q;
	logic [CNT_BITS-1:0]   prime_cnt_q;
	logic                  lock_q;

	logic                  smp_ok;
	logic [ALPHA_BITS-1:0] a_sat;
	logic [ALPHA_BITS-1:0] a_rem;
	logic [FILT_BITS-1:0]  scaled;
	logic [PROD_BITS-1:0]  p_new;
	logic [PROD_BITS-1:0]  p_old;
	logic [SUM_BITS-1:0]   sum;
	logic [FILT_BITS-1:0]  f_upd;
	logic [FILT_BITS-1:0]  f_nxt;
	logic [FILT_BITS-1:0]  t_nxt;
	logic [CNT_BITS-1:0]   cnt_inc;
	logic [CNT_BITS-1:0]   need;
	logic                  lock_nxt;
	logic [FILT_BITS-1:0]  band;
	logic [FILT_BITS-1:0]  err_mag;
	logic                  above;
	logic [DIR_BITS-1:0]   dir;

	assign smp_ok = (status != cfg.invalid_code);
	assign a_sat  = (cfg.alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q8;
	assign a_rem  = ALPHA_ONE - a_sat;
	assign scaled = {raw, {FRAC_BITS{1'b0}}};
	assign p_new  = PROD_BITS'(a_sat) * PROD_BITS'(scaled);
	assign p_old  = PROD_BITS'(a_rem) * PROD_BITS'(filter_q);
	assign sum    = SUM_BITS'(p_new) + SUM_BITS'(p_old);
	assign f_upd  = sum[ALPHA_FRAC +: FILT_BITS];

	assign cnt_inc = (prime_cnt_q == CNT_MAX) ? prime_cnt_q : prime_cnt_q + 1'b1;
	assign need    = (cfg.prime_count == '0) ? CNT_BITS'(1) : cfg.prime_count;

	always_comb begin
		f_nxt    = filter_q;
		t_nxt    = target_q;
		lock_nxt = lock_q;
		if (!lock_q) begin
			// Seeding an empty filter with the raw sample and then blending it
			// with itself leaves exactly the scaled raw value.
			if (smp_ok) begin
				f_nxt = (filter_q == '0) ? scaled : f_upd;
			end
			if (cnt_inc >= need) begin
				t_nxt    = f_nxt;
				lock_nxt = 1'b1;
			end
		end else if (smp_ok) begin
			f_nxt = f_upd;
		end
	end

	assign band    = FILT_BITS'({cfg.deadband_mm, {FRAC_BITS{1'b0}}});
	assign above   = (f_nxt > target_q);
	assign err_mag = above ? (f_nxt - target_q) : (target_q - f_nxt);

	always_comb begin
		dir = DIR_STOP;
		if (lock_q && smp_ok && (err_mag > band)) begin
			dir = above ? DIR_FWD : DIR_REV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q    <= '0;
			target_q    <= '0;
			prime_cnt_q <= '0;
			lock_q      <= 1'b0;
		end else if (step) begin
			filter_q <= f_nxt;
			target_q <= t_nxt;
			lock_q   <= lock_nxt;
			if (!lock_q) begin
				prime_cnt_q <= cnt_inc;
			end
		end
	end

	assign res.direction   = dir;
	assign res.duty        = (dir == DIR_STOP) ? '0 : cfg.drive_duty;
	assign res.filtered_mm = f_nxt[FILT_BITS-1 -: DIST_BITS];
	assign res.target_mm   = lock_nxt ? t_nxt[FILT_BITS-1 -: DIST_BITS] : '0;
	assign res.locked      = lock_nxt;

endmodule

`default_nettype wire

>>> rtl/ema_deadband_bang_bang_ctrl_core.sv
// ----------------------------------------------------------------------------
// ema_deadband_bang_bang_ctrl_core
// Range-sample EMA filter with priming, setpoint lock and deadband drive.
// ----------------------------------------------------------------------------
//  channel | role   | payload                                          | handshake
//  sample  | sink   | distance_mm, range_status                        | valid/ready
//  result  | source | direction, duty, filtered_mm, target_mm, locked  | valid/ready
//  cfg     | sink   | index, data                                      | valid/ready
//
//  One request per cycle is sustained while the result is not stalled; each
//  sample passes the input register and then the result register. The filter
//  state loop is combinational, through two 9 x 21 multipliers and an adder.
//  Reset clears the filter state and loads the register defaults.
//  A stalled result holds the input register; a new request is still taken
//  whenever the input register is empty or moves on in the same cycle.
//  Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ema_deadband_bang_bang_ctrl_core_macros.svh"

module ema_deadband_bang_bang_ctrl_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ebb_sample_if.sink   sample,
	ebb_result_if.source result,
	ebb_cfg_if.sink      cfg
);
	import ebb_pkg::*;

	cfg_t                 cfg_cur;
	res_t                 res_nxt;
	res_t                 res_q;
	logic                 out_vld_q;
	logic                 vld_s1;
	logic [DIST_BITS-1:0] dist_s1;
	logic [STAT_BITS-1:0] stat_s1;
	logic                 advance;
	logic                 take;

	assign cfg.ready = 1'b1;

	ebb_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_idx  (cfg.index),
		.wr_data (cfg.data),
		.cfg     (cfg_cur)
	);

	assign advance      = vld_s1 && (!out_vld_q || result.ready);
	assign take         = sample.valid && sample.ready;
	assign sample.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample.ready) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dist_s1 <= sample.distance_mm;
			stat_s1 <= sample.range_status;
		end
	end

	ebb_loop u_loop (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.raw    (dist_s1),
		.status (stat_s1),
		.cfg    (cfg_cur),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.direction   = res_q.direction;
	assign result.duty        = res_q.duty;
	assign result.filtered_mm = res_q.filtered_mm;
	assign result.target_mm   = res_q.target_mm;
	assign result.locked      = res_q.locked;

	// A processed item always shows up as a pending result.
	`EBB_ASSERT_NXT(a_adv_gives_result, advance, out_vld_q)
	// A held input item is not lost while the output is stalled.
	`EBB_ASSERT_NXT(a_s1_held, vld_s1 && !advance, vld_s1)
	// The motor only drives once the setpoint is locked.
	`EBB_ASSERT_IMP(a_drive_needs_lock, out_vld_q && (res_q.direction != DIR_STOP), res_q.locked)
	// Before lock there is no setpoint to report.
	`EBB_ASSERT_IMP(a_no_target_unlocked, out_vld_q && !res_q.locked, res_q.target_mm == '0)

endmodule

`default_nettype wire
